>>> design/bfba_pkg.sv
// shared constants for the bitmap free block allocator
// operation and status codes, field widths, parameter defaults
package bfba_pkg;

    localparam int WORDS_DEF     = 64;
    localparam int WORD_BITS_DEF = 64;

    localparam int NUM_W  = 16;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [OP_W-1:0] OP_GET   = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic CFG_LOWEST  = 1'b0;
    localparam logic CFG_HIGHEST = 1'b1;

    localparam logic [NUM_W-1:0] LOWEST_RST  = 16'd0;
    localparam logic [NUM_W-1:0] HIGHEST_RST = 16'd4095;

endpackage

>>> design/bfba_split.sv
// splits a bit offset into word index and bit position
// reciprocal multiply registered, then one correction step; uses bfba_pkg
module bfba_split #(
    parameter int WORD_BITS = bfba_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic [bfba_pkg::NUM_W-1:0]           dividend,
    output logic [bfba_pkg::NUM_W-1:0]           quot,
    output logic [$clog2(WORD_BITS)-1:0]         rem
);

    localparam int NW    = bfba_pkg::NUM_W;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int SH    = NW + 8;
    localparam int RW    = SH - 2;
    localparam int PW    = NW + RW;
    localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / WORD_BITS);
    localparam logic [NW:0]   WB    = (NW+1)'(WORD_BITS);

    logic [NW-1:0] dividend_reg;
    logic [NW-1:0] q0_reg;
    logic [PW-1:0] prod;
    logic [NW:0]   back;
    logic [NW:0]   r0;

    assign prod = PW'(dividend) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend;
        q0_reg       <= NW'(prod >> SH);
    end

    always_comb
    begin
        back = (NW+1)'(q0_reg) * WB;
        r0   = (NW+1)'(dividend_reg) - back;
        if (r0 >= WB)
        begin
            quot = q0_reg + NW'(1);
            rem  = BW'(r0 - WB);
        end
        else
        begin
            quot = q0_reg;
            rem  = BW'(r0);
        end
    end

endmodule

>>> design/bitmap_free_block_allocator.sv
// get/set/clear: word split (S_DIV, S_SPL), bit read or update (S_MOD), result (S_DONE)
// out of range skips S_MOD; find reads (S_SRD) and checks (S_SCHK) one bitmap word at a time
// word split and bitmap read are both registered; a new request is taken only in S_IDLE
// after reset a clearing pass zeroes the bitmap word by word, with in_stall high
// reset: lowest 0, highest 4095, cursor 0, every block free
// uses bfba_pkg and bfba_split
module bitmap_free_block_allocator #(
    parameter int WORDS     = bfba_pkg::WORDS_DEF,
    parameter int WORD_BITS = bfba_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bfba_pkg::OP_W-1:0]         operation,
    input  logic [bfba_pkg::NUM_W-1:0]        block_number,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bfba_pkg::STAT_W-1:0]       status,
    output logic                              bit_value,
    output logic [bfba_pkg::NUM_W-1:0]        free_number,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [bfba_pkg::NUM_W-1:0]        cfg_data
);

    localparam int NW  = bfba_pkg::NUM_W;
    localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW  = $clog2(WORD_BITS);
    localparam int CAP = WORDS * WORD_BITS;
    localparam logic [NW:0]   CAP_M1   = (NW+1)'(CAP - 1);
    localparam logic [AW-1:0] LAST_ADR = AW'(WORDS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SPL  = 3'd3;
    localparam logic [2:0] S_MOD  = 3'd4;
    localparam logic [2:0] S_SRD  = 3'd5;
    localparam logic [2:0] S_SCHK = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [AW-1:0]        mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [2:0]                  state_reg, state_next;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [AW-1:0]               search_reg, search_next;
    logic [AW-1:0]               cur_reg, cur_next;
    logic [NW-1:0]               lowest_reg, highest_reg;
    logic [bfba_pkg::OP_W-1:0]   op_reg, op_next;
    logic [NW-1:0]               num_reg, num_next;
    logic [NW-1:0]               word_reg, word_next;
    logic [BW-1:0]               bit_reg, bit_next;
    logic [bfba_pkg::STAT_W-1:0] rstat_reg, rstat_next;
    logic                        rbit_reg, rbit_next;
    logic [NW-1:0]               rfree_reg, rfree_next;
    logic                        out_valid_reg, out_valid_next;
    logic [bfba_pkg::STAT_W-1:0] status_reg, status_next;
    logic                        bit_value_reg, bit_value_next;
    logic [NW-1:0]               free_reg, free_next;

    logic          nonempty;
    logic [NW-1:0] diff;
    logic [NW-1:0] span;
    logic [NW-1:0] idx;
    logic          in_range;
    logic [NW-1:0] dividend;
    logic [NW-1:0] quot;
    logic [BW-1:0] rem;

    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] zeros;
    logic [BW-1:0]        first_b;
    logic [WORD_BITS-1:0] onehot;
    logic [31:0]          base_off;
    logic                 out_free;

    // range and offset from configuration
    always_comb
    begin
        nonempty = lowest_reg <= highest_reg;
        diff     = highest_reg - lowest_reg;
        span     = ((NW+1)'(diff) > CAP_M1) ? NW'(CAP_M1) : diff;
        idx      = num_reg - lowest_reg;
        in_range = nonempty && (num_reg >= lowest_reg) && (idx <= span);
        dividend = (op_reg == bfba_pkg::OP_FIND) ? span : idx;
    end

    bfba_split #(
        .WORD_BITS (WORD_BITS)
    ) u_split (
        .clk      (clk),
        .dividend (dividend),
        .quot     (quot),
        .rem      (rem)
    );

    // word check for find
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            valid_mask[i] = ((NW'(cur_reg) != word_reg) || (BW'(i) <= bit_reg));
        end
        zeros   = ~rdata_reg & valid_mask;
        first_b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (zeros[i])
            begin
                first_b = BW'(i);
            end
        end
        onehot   = WORD_BITS'(1) << bit_reg;
        base_off = 32'(cur_reg) * 32'(WORD_BITS);
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        search_next    = search_reg;
        cur_next       = cur_reg;
        op_next        = op_reg;
        num_next       = num_reg;
        word_next      = word_reg;
        bit_next       = bit_reg;
        rstat_next     = rstat_reg;
        rbit_next      = rbit_reg;
        rfree_next     = rfree_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        bit_value_next = bit_value_reg;
        free_next      = free_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_reg[AW-1:0];
        mem_wdata      = rdata_reg;
        mem_raddr      = cur_reg;

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == LAST_ADR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = operation;
                    num_next   = block_number;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_SPL;
            end
            S_SPL:
            begin
                word_next  = quot;
                bit_next   = rem;
                rstat_next = bfba_pkg::ST_OK;
                rbit_next  = 1'b0;
                rfree_next = '0;
                mem_raddr  = quot[AW-1:0];
                if (op_reg != bfba_pkg::OP_FIND)
                begin
                    if (in_range)
                    begin
                        state_next = S_MOD;
                    end
                    else
                    begin
                        rstat_next = bfba_pkg::ST_RANGE;
                        state_next = S_DONE;
                    end
                end
                else if (!nonempty || (NW'(search_reg) > quot))
                begin
                    rstat_next = bfba_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = search_reg;
                    state_next = S_SRD;
                end
            end
            S_MOD:
            begin
                case (op_reg)
                    bfba_pkg::OP_GET:
                    begin
                        rbit_next = rdata_reg[bit_reg];
                    end
                    bfba_pkg::OP_SET:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg | onehot;
                    end
                    bfba_pkg::OP_CLEAR:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg & ~onehot;
                        if (search_reg > word_reg[AW-1:0])
                        begin
                            search_next = word_reg[AW-1:0];
                        end
                    end
                    default:
                    begin
                        rbit_next = 1'b0;
                    end
                endcase
                state_next = S_DONE;
            end
            S_SRD:
            begin
                mem_raddr  = cur_reg;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (zeros != '0)
                begin
                    search_next = cur_reg;
                    rfree_next  = lowest_reg + NW'(base_off) + NW'(first_b);
                    state_next  = S_DONE;
                end
                else if (NW'(cur_reg) == word_reg)
                begin
                    rstat_next = bfba_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = cur_reg + AW'(1);
                    state_next = S_SRD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rstat_reg;
                    bit_value_next = rbit_reg;
                    free_next      = rfree_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            search_reg    <= '0;
            out_valid_reg <= 1'b0;
            lowest_reg    <= bfba_pkg::LOWEST_RST;
            highest_reg   <= bfba_pkg::HIGHEST_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (cfg_index == bfba_pkg::CFG_LOWEST)
                begin
                    lowest_reg <= cfg_data;
                end
                else
                begin
                    highest_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        op_reg        <= op_next;
        num_reg       <= num_next;
        word_reg      <= word_next;
        bit_reg       <= bit_next;
        rstat_reg     <= rstat_next;
        rbit_reg      <= rbit_next;
        rfree_reg     <= rfree_next;
        status_reg    <= status_next;
        bit_value_reg <= bit_value_next;
        free_reg      <= free_next;
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign bit_value   = bit_value_reg;
    assign free_number = free_reg;

endmodule

>>> verif/tb_top.sv
// testbench for bitmap_free_block_allocator: directed table, then random
// phases over several block ranges, checked word by word against the table or a predictor
// depends on bfba_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int WORDS_N   = bfba_pkg::WORDS_DEF;
    localparam int BITS      = bfba_pkg::WORD_BITS_DEF;
    localparam int CAP       = WORDS_N * BITS;
    localparam int NUM_W     = bfba_pkg::NUM_W;
    localparam int OP_W      = bfba_pkg::OP_W;
    localparam int STAT_W    = bfba_pkg::STAT_W;
    localparam int LIMIT     = 1000000;
    localparam int HOLD_LEN  = 300;
    localparam int TAIL_WAIT = 150;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              bit_value;
        logic [NUM_W-1:0]  free_number;
    } alloc_result_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [NUM_W-1:0] num;
        logic             typed;
        alloc_result_t    want;
    } directed_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   operation = bfba_pkg::OP_GET;
    logic [NUM_W-1:0]  block_number = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [STAT_W-1:0] status;
    logic              bit_value;
    logic [NUM_W-1:0]  free_number;
    logic              cfg_write = 1'b0;
    logic              cfg_index = bfba_pkg::CFG_LOWEST;
    logic [NUM_W-1:0]  cfg_data = '0;

    // predictor state
    logic [BITS-1:0]  used_map [WORDS_N];
    int unsigned      cursor_word = 0;
    logic [NUM_W-1:0] cfg_lowest = bfba_pkg::LOWEST_RST;
    bit               range_ok = 1'b1;
    int unsigned      tracked_span = 32'(bfba_pkg::HIGHEST_RST) - 32'(bfba_pkg::LOWEST_RST);

    alloc_result_t pending_results [$];
    alloc_result_t last_outcome;
    directed_row_t directed_rows [0:23];
    int            mismatches = 0;
    int            cycle_count = 0;
    int            hold_reqs = 0;
    bit            quiet_spell = 1'b0;

    bitmap_free_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .block_number (block_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .bit_value    (bit_value),
        .free_number  (free_number),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic alloc_result_t allocator_predict(input logic [OP_W-1:0] op,
                                                        input logic [NUM_W-1:0] num);
        alloc_result_t r;
        int unsigned   idx;
        int unsigned   w;
        int unsigned   b;
        int unsigned   last;
        int unsigned   rem;
        bit            found;
        logic [BITS-1:0] mask;
        logic [BITS-1:0] zeros;
        r = '0;
        if (op != bfba_pkg::OP_FIND)
        begin
            idx = 32'(num) - 32'(cfg_lowest);
            if (!range_ok || num < cfg_lowest || idx > tracked_span)
                r.status = bfba_pkg::ST_RANGE;
            else
            begin
                w = idx / BITS;
                b = idx % BITS;
                case (op)
                    bfba_pkg::OP_GET: r.bit_value = used_map[w][b];
                    bfba_pkg::OP_SET: used_map[w][b] = 1'b1;
                    default:
                    begin
                        used_map[w][b] = 1'b0;
                        if (cursor_word > w)
                            cursor_word = w;
                    end
                endcase
            end
        end
        else
        begin
            r.status = bfba_pkg::ST_FULL;
            if (range_ok)
            begin
                last = tracked_span / BITS;
                rem = tracked_span % BITS;
                found = 1'b0;
                for (w = cursor_word; !found && w <= last && w < WORDS_N; w++)
                begin
                    mask = '1;
                    if (w == last && rem < BITS - 1)
                        mask = (64'd1 << (rem + 1)) - 64'd1;
                    zeros = ~used_map[w] & mask;
                    if (zeros != '0)
                    begin
                        b = 0;
                        while (!zeros[b])
                            b++;
                        cursor_word = w;
                        r.free_number = NUM_W'(cfg_lowest + w * BITS + b);
                        r.status = bfba_pkg::ST_OK;
                        found = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] pick_tracked_number();
        if (!range_ok)
            return NUM_W'($urandom);
        case ($urandom_range(7))
            0: return cfg_lowest;
            1: return NUM_W'(cfg_lowest + tracked_span);
            default: return NUM_W'(cfg_lowest + $urandom_range(tracked_span));
        endcase
    endfunction

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num,
                             input bit typed = 1'b0, input alloc_result_t want = '0);
        alloc_result_t predicted;
        while (!quiet_spell && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        block_number <= num;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
        predicted = allocator_predict(op, num);
        last_outcome = predicted;
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_range(input logic [NUM_W-1:0] lo, input logic [NUM_W-1:0] hi);
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= bfba_pkg::CFG_LOWEST;
        cfg_data <= lo;
        @(posedge clk);
        cfg_index <= bfba_pkg::CFG_HIGHEST;
        cfg_data <= hi;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_lowest = lo;
        range_ok = lo <= hi;
        tracked_span = range_ok ? 32'(hi) - 32'(lo) : 0;
        if (tracked_span > CAP - 1)
            tracked_span = CAP - 1;
    endtask

    task automatic run_random(input int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 48)
            begin
                // find a free block, then claim it
                send_word(bfba_pkg::OP_FIND, NUM_W'($urandom));
                sent++;
                if (last_outcome.status == bfba_pkg::ST_OK)
                begin
                    send_word(bfba_pkg::OP_SET, last_outcome.free_number);
                    sent++;
                end
            end
            else
            begin
                if (pick < 60)
                    send_word(bfba_pkg::OP_SET, pick_tracked_number());
                else if (pick < 70)
                    send_word(bfba_pkg::OP_CLEAR, pick_tracked_number());
                else if (pick < 80)
                    send_word(bfba_pkg::OP_GET, pick_tracked_number());
                else
                    send_word(OP_W'($urandom_range(3)), NUM_W'($urandom));
                sent++;
            end
        end
    endtask

    // result side: stall at negedge-stable points, check at negedge
    initial
    begin
        int hold_seen;
        int hold_left;
        alloc_result_t want;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet_spell && $urandom_range(99) < 17;
            @(negedge clk);
            if (rst_n && out_valid === 1'b1 && !out_stall)
            begin
                if (pending_results.size() == 0)
                    log_mismatch("word with nothing pending, status", int'(status), -1);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        log_mismatch("status", int'(status), int'(want.status));
                    if (bit_value !== want.bit_value)
                        log_mismatch("bit_value", int'(bit_value), int'(want.bit_value));
                    if (free_number !== want.free_number)
                        log_mismatch("free_number", int'(free_number),
                                     int'(want.free_number));
                end
            end
        end
    end

    initial
    begin
        foreach (used_map[i])
            used_map[i] = '0;
        directed_rows = '{
            '{bfba_pkg::OP_GET,   16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_FIND,  16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_SET,   16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b1, 16'd0}},
            '{bfba_pkg::OP_FIND,  16'd65535, 1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd1}},
            '{bfba_pkg::OP_SET,   16'd4095,  1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd4095,  1'b1, '{bfba_pkg::ST_OK,    1'b1, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd4096,  1'b1, '{bfba_pkg::ST_RANGE, 1'b0, 16'd0}},
            '{bfba_pkg::OP_SET,   16'd65535, 1'b1, '{bfba_pkg::ST_RANGE, 1'b0, 16'd0}},
            '{bfba_pkg::OP_CLEAR, 16'd65535, 1'b1, '{bfba_pkg::ST_RANGE, 1'b0, 16'd0}},
            '{bfba_pkg::OP_FIND,  16'd0,     1'b0, '0},
            '{bfba_pkg::OP_SET,   16'd1,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_SET,   16'd63,    1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_FIND,  16'd0,     1'b0, '0},
            '{bfba_pkg::OP_CLEAR, 16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_FIND,  16'd0,     1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd63,    1'b1, '{bfba_pkg::ST_OK,    1'b1, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd64,    1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_CLEAR, 16'd4095,  1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_GET,   16'd4095,  1'b1, '{bfba_pkg::ST_OK,    1'b0, 16'd0}},
            '{bfba_pkg::OP_SET,   16'd2,     1'b0, '0},
            '{bfba_pkg::OP_GET,   16'd2,     1'b0, '0},
            '{bfba_pkg::OP_FIND,  16'd0,     1'b0, '0},
            '{bfba_pkg::OP_GET,   16'd65535, 1'b1, '{bfba_pkg::ST_RANGE, 1'b0, 16'd0}}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].op, directed_rows[i].num,
                      directed_rows[i].typed, directed_rows[i].want);

        set_range(16'd0, 16'd95);
        run_random(330);
        // cursor is likely past the shrunken range here
        set_range(16'd0, 16'd40);
        run_random(100);
        set_range(16'd65535, 16'd65535);
        run_random(50);
        set_range(16'd0, 16'd0);
        run_random(40);
        set_range(16'd500, 16'd499);
        run_random(50);
        set_range(16'd1000, 16'd65535);
        hold_reqs <= hold_reqs + 1;
        run_random(250);
        set_range(16'd65000, 16'd65535);
        run_random(120);
        wait_drained();
        run_random(120);
        set_range(16'd0, 16'd65535);
        quiet_spell <= 1'b1;
        run_random(200);
        set_range(16'd62000, 16'd62063);
        quiet_spell <= 1'b0;
        run_random(190);

        wait_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
design/bfba_pkg.sv
design/bfba_split.sv
design/bitmap_free_block_allocator.sv
verif/tb_top.sv
